[hw/rtl/c3f_pkg.sv]
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared types and constants of the 3x3 image filter.
// ----------------------------------------------------------------------------
package c3f_pkg;

    // register map, index = byte address / 8
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_COEF_T = 3'd2;
    localparam logic [2:0] REG_COEF_M = 3'd3;
    localparam logic [2:0] REG_COEF_B = 3'd4;
    localparam logic [2:0] REG_MERGE  = 3'd5;
    localparam logic [2:0] REG_CHUSED = 3'd6;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int WIN_DIM       = 3;
    localparam int NUM_CHANNELS  = 3;
    // channels_used is capped here
    localparam int NCH_CAP = (NUM_CHANNELS < 3) ? NUM_CHANNELS : 3;

    localparam int PIX_W  = 24;
    localparam int TAP_W  = 12;
    localparam int COEF_W = 36;
    localparam int OCOL_W = 10;
    localparam int ROW_W  = 16;
    localparam int SUM_W  = 25;
    localparam int CSUM_W = 24;

    localparam logic [10:0] RST_WIDTH  = 11'd1024;
    localparam logic [15:0] RST_HEIGHT = 16'd1;
    localparam logic [35:0] RST_COEF_M = 36'h0_0010_0000;

    // per-item control traveling down the pipeline
    typedef struct packed {
        logic              emit_a;   // result for column c-1
        logic              emit_b;   // result for the last column
        logic              last_a;   // run_last on result A
        logic              done_b;   // frame_done on result B
        logic [OCOL_W-1:0] col_a;
        logic [OCOL_W-1:0] col_b;
        logic [ROW_W-1:0]  row;
    } t_ctrl;

endpackage

[hw/rtl/c3f_if.sv]
// ----------------------------------------------------------------------------
// c3f_if
// Valid/ready channels of the filter: pixel input and result output.
// ----------------------------------------------------------------------------
interface c3f_pix_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;

    modport source (output valid, opcode, chan0, chan1, chan2, input ready);
    modport sink   (input valid, opcode, chan0, chan1, chan2, output ready);
endinterface

interface c3f_res_if;
    logic               valid;
    logic               ready;
    logic [9:0]         out_col;
    logic [15:0]        out_row;
    logic signed [24:0] sum0;
    logic signed [23:0] sum1;
    logic signed [23:0] sum2;
    logic               run_last;
    logic               frame_done;

    modport source (output valid, out_col, out_row, sum0, sum1, sum2, run_last,
                    frame_done, input ready);
    modport sink   (input valid, out_col, out_row, sum0, sum1, sum2, run_last,
                    frame_done, output ready);
endinterface

[hw/rtl/conv3x3_image_filter.sv]
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// Streaming 3x3 filter, edge clamped, three 8-bit channels, Q4.8 kernel.
// ----------------------------------------------------------------------------
// Pipeline: a result passes the stage 1 registers, the window, the kernel
//   stages and the output register; the second result of a last column follows it.
// Throughput: one pixel or drain tick per cycle while the output takes results;
//   the last column of a row wider than one pixel yields two results, so it
//   holds the pipeline until the first of them has left the output.
// Reset (i_rst_n, synchronous): counters, window, valid bits and registers go
//   to their reset values; the row stores are not cleared.
// ----------------------------------------------------------------------------
module conv3x3_image_filter #(
    parameter int MAX_WIDTH = c3f_pkg::DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    c3f_pix_if.sink                       i_pix,
    c3f_res_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [c3f_pkg::ADDR_W-1:0]    paddr,
    input  logic [c3f_pkg::DATA_W-1:0]    pwdata,
    output logic [c3f_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import c3f_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (CW > 11) ? CW : 11;

    // configuration
    logic [10:0]       r_width;
    logic [15:0]       r_height;
    logic [COEF_W-1:0] r_coef [3];
    logic              r_merge;
    logic [1:0]        r_chused;
    logic [2:0]        w_ch_en;
    logic [2:0]        w_idx;

    // input counters
    logic [CW-1:0]    r_in_col, r_drain_col;
    logic [ROW_W-1:0] r_in_row;

    // stage 0 decode
    logic [WW-1:0]    w_w_in, w_w_eff;
    logic [ROW_W-1:0] w_h_eff;
    logic             w_complete, w_drain, w_ign, w_lastc, w_produce, w_acc;
    logic [CW-1:0]    w_c;
    logic [WW:0]      w_c_next;
    logic [PIX_W-1:0] w_px;
    t_ctrl            w_ctrl;
    logic             w_adv;

    // stage 1
    logic             r_s1_v, r_s1_drain, r_s1_row0, r_s1_first;
    logic [PIX_W-1:0] r_s1_px;
    logic [AW-1:0]    r_s1_addr;
    t_ctrl            r_s1_ctrl;
    logic [PIX_W-1:0] w_rd_up, w_rd_lo, w_top, w_mid, w_bot;
    logic             w_wr_en;

    // stage 2: window
    logic [PIX_W-1:0] r_win [3][3];
    logic             r_s2_v;
    t_ctrl            r_s2_ctrl;

    // mac out / output register
    logic                    w_m_v;
    t_ctrl                   w_m_ctrl;
    logic signed [SUM_W-1:0] w_m_sum [2][3];
    logic                    r_ov_a, r_ov_b;
    logic signed [SUM_W-1:0] r_sum_a [3];
    logic signed [SUM_W-1:0] r_sum_b [3];
    t_ctrl                   r_octrl;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_WIDTH;
            r_height  <= RST_HEIGHT;
            r_coef[0] <= '0;
            r_coef[1] <= RST_COEF_M;
            r_coef[2] <= '0;
            r_merge   <= 1'b0;
            r_chused  <= 2'd3;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_WIDTH:  r_width   <= pwdata[10:0];
                REG_HEIGHT: r_height  <= pwdata[15:0];
                REG_COEF_T: r_coef[0] <= pwdata[COEF_W-1:0];
                REG_COEF_M: r_coef[1] <= pwdata[COEF_W-1:0];
                REG_COEF_B: r_coef[2] <= pwdata[COEF_W-1:0];
                REG_MERGE:  r_merge   <= pwdata[0];
                REG_CHUSED: r_chused  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_WIDTH:  prdata = DATA_W'(r_width);
            REG_HEIGHT: prdata = DATA_W'(r_height);
            REG_COEF_T: prdata = DATA_W'(r_coef[0]);
            REG_COEF_M: prdata = DATA_W'(r_coef[1]);
            REG_COEF_B: prdata = DATA_W'(r_coef[2]);
            REG_MERGE:  prdata = DATA_W'(r_merge);
            REG_CHUSED: prdata = DATA_W'(r_chused);
            default:    prdata = '0;
        endcase
    end

    // channel enables: 0 counts as 1, capped
    always_comb begin
        int n;
        n = (r_chused == 2'd0) ? 1 : int'(r_chused);
        if (n > NCH_CAP) n = NCH_CAP;
        for (int ch = 0; ch < 3; ch++)
            w_ch_en[ch] = (ch < n);
    end

    // ---------------- stage 0: sequencing ----------------
    assign w_w_in   = WW'(r_width);
    assign w_w_eff  = (w_w_in == '0) ? WW'(1) :
                      (w_w_in > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_w_in;
    assign w_h_eff  = (r_height == '0) ? ROW_W'(1) : r_height;
    assign w_complete = (r_in_row >= w_h_eff);
    assign w_drain  = i_pix.opcode;
    assign w_c      = w_drain ? r_drain_col : r_in_col;
    assign w_ign    = (w_drain ? !w_complete : w_complete) || (w_c >= CW'(MAX_WIDTH));
    assign w_c_next = (WW+1)'(w_c) + (WW+1)'(1);
    assign w_lastc  = (w_c_next >= (WW+1)'(w_w_eff));
    assign w_produce = w_drain || (r_in_row != '0);
    assign w_px     = {i_pix.chan2, i_pix.chan1, i_pix.chan0};

    always_comb begin
        w_ctrl.emit_a = !w_ign && w_produce && (w_c != '0);
        w_ctrl.emit_b = !w_ign && w_produce && w_lastc;
        w_ctrl.last_a = !w_lastc;
        w_ctrl.done_b = w_drain;
        w_ctrl.col_a  = OCOL_W'(w_c - CW'(1));
        w_ctrl.col_b  = OCOL_W'(w_c);
        w_ctrl.row    = r_in_row - ROW_W'(1);
    end

    // pipeline moves when the output is empty, or holds one result that is taken
    assign w_adv       = !(r_ov_a || r_ov_b) || (o_res.ready && !(r_ov_a && r_ov_b));
    assign i_pix.ready = w_adv;
    assign w_acc       = i_pix.valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_drain_col <= '0;
        end else if (w_acc && !w_ign) begin
            if (!w_drain) begin
                if (w_lastc) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= CW'(w_c_next);
                end
            end else if (w_lastc) begin
                r_drain_col <= '0;
                r_in_col    <= '0;
                r_in_row    <= '0;
            end else begin
                r_drain_col <= CW'(w_c_next);
            end
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= w_acc && !w_ign;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_drain <= w_drain;
            r_s1_row0  <= (r_in_row == '0);
            r_s1_first <= (w_c == '0);
            r_s1_px    <= w_px;
            r_s1_addr  <= w_c[AW-1:0];
            r_s1_ctrl  <= w_ctrl;
        end
    end

    // ---------------- stage 1: row stores ----------------
    assign w_wr_en = w_adv && r_s1_v && !r_s1_drain;

    c3f_linebuf #(.MAX_WIDTH(MAX_WIDTH)) u_linebuf (
        .i_clk     (i_clk),
        .i_adv     (w_adv),
        .i_rd_addr (w_c[AW-1:0]),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_up   (w_mid),
        .i_wr_lo   (r_s1_px),
        .o_rd_up   (w_rd_up),
        .o_rd_lo   (w_rd_lo)
    );

    // column entering the window; row 0 repeats the pixel upward,
    // drain repeats row r-1 downward
    always_comb begin
        if (r_s1_drain) begin
            w_top = w_rd_up;
            w_mid = w_rd_lo;
            w_bot = w_rd_lo;
        end else begin
            w_top = r_s1_row0 ? r_s1_px : w_rd_up;
            w_mid = r_s1_row0 ? r_s1_px : w_rd_lo;
            w_bot = r_s1_px;
        end
    end

    // window: first column fills all three, else shift left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 3; p++)
                for (int q = 0; q < 3; q++)
                    r_win[p][q] <= '0;
        end else if (w_adv && r_s1_v) begin
            for (int p = 0; p < 2; p++) begin
                if (r_s1_first) begin
                    r_win[p][0] <= w_top;
                    r_win[p][1] <= w_mid;
                    r_win[p][2] <= w_bot;
                end else begin
                    r_win[p] <= r_win[p+1];
                end
            end
            r_win[2][0] <= w_top;
            r_win[2][1] <= w_mid;
            r_win[2][2] <= w_bot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_adv) begin
            r_s2_v <= r_s1_v && (r_s1_ctrl.emit_a || r_s1_ctrl.emit_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_s2_ctrl <= r_s1_ctrl;
    end

    // ---------------- stages 3..5: kernel ----------------
    c3f_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_s2_v),
        .i_ctrl  (r_s2_ctrl),
        .i_win   (r_win),
        .i_coef  (r_coef),
        .i_ch_en (w_ch_en),
        .i_merge (r_merge),
        .o_valid (w_m_v),
        .o_ctrl  (w_m_ctrl),
        .o_sum   (w_m_sum)
    );

    // ---------------- output register: A then B ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov_a <= 1'b0;
            r_ov_b <= 1'b0;
        end else if (w_adv) begin
            r_ov_a <= w_m_v && w_m_ctrl.emit_a;
            r_ov_b <= w_m_v && w_m_ctrl.emit_b;
        end else if (o_res.ready) begin
            // both pending: A leaves first
            r_ov_a <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum_a <= w_m_sum[0];
            r_sum_b <= w_m_sum[1];
            r_octrl <= w_m_ctrl;
        end
    end

    assign o_res.valid      = r_ov_a || r_ov_b;
    assign o_res.out_col    = r_ov_a ? r_octrl.col_a : r_octrl.col_b;
    assign o_res.out_row    = r_octrl.row;
    assign o_res.sum0       = r_ov_a ? r_sum_a[0] : r_sum_b[0];
    assign o_res.sum1       = r_ov_a ? r_sum_a[1][CSUM_W-1:0] : r_sum_b[1][CSUM_W-1:0];
    assign o_res.sum2       = r_ov_a ? r_sum_a[2][CSUM_W-1:0] : r_sum_b[2][CSUM_W-1:0];
    assign o_res.run_last   = r_ov_a ? r_octrl.last_a : 1'b1;
    assign o_res.frame_done = r_ov_a ? 1'b0 : r_octrl.done_b;

endmodule

[hw/rtl/c3f_linebuf.sv]
// ----------------------------------------------------------------------------
// c3f_linebuf
// Two row stores (rows r-2 and r-1) with registered read and write bypass.
// ----------------------------------------------------------------------------
module c3f_linebuf #(
    parameter int MAX_WIDTH = c3f_pkg::DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_adv,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_wr_addr,
    input  logic [c3f_pkg::PIX_W-1:0]     i_wr_up,
    input  logic [c3f_pkg::PIX_W-1:0]     i_wr_lo,
    output logic [c3f_pkg::PIX_W-1:0]     o_rd_up,
    output logic [c3f_pkg::PIX_W-1:0]     o_rd_lo
);
    import c3f_pkg::*;

    logic [PIX_W-1:0] r_mem_up [MAX_WIDTH];
    logic [PIX_W-1:0] r_mem_lo [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_up, r_rd_lo, r_byp_up, r_byp_lo;
    logic             r_byp;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_up[i_wr_addr] <= i_wr_up;
            r_mem_lo[i_wr_addr] <= i_wr_lo;
        end
    end

    // read port; a write to the same column in the same cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd_up  <= r_mem_up[i_rd_addr];
            r_rd_lo  <= r_mem_lo[i_rd_addr];
            r_byp    <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_byp_up <= i_wr_up;
            r_byp_lo <= i_wr_lo;
        end
    end

    assign o_rd_up = r_byp ? r_byp_up : r_rd_up;
    assign o_rd_lo = r_byp ? r_byp_lo : r_rd_lo;

endmodule

[hw/rtl/c3f_mac.sv]
// ----------------------------------------------------------------------------
// c3f_mac
// Kernel datapath: products, row sums, channel sums and merge, 3 stages.
// ----------------------------------------------------------------------------
module c3f_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  c3f_pkg::t_ctrl                    i_ctrl,
    input  logic [c3f_pkg::PIX_W-1:0]         i_win [3][3],
    input  logic [c3f_pkg::COEF_W-1:0]        i_coef [3],
    input  logic [2:0]                        i_ch_en,
    input  logic                              i_merge,
    output logic                              o_valid,
    output c3f_pkg::t_ctrl                    o_ctrl,
    output logic signed [c3f_pkg::SUM_W-1:0]  o_sum [2][3]
);
    import c3f_pkg::*;

    logic signed [TAP_W-1:0] w_tap [3][3];
    logic signed [20:0] n_prod [2][3][3][3];
    logic signed [20:0] r_prod [2][3][3][3];
    logic signed [22:0] n_rsum [2][3][3];
    logic signed [22:0] r_rsum [2][3][3];
    logic signed [SUM_W-1:0] n_tot [2][3];
    logic signed [SUM_W-1:0] n_sum [2][3];
    logic  r_v1, r_v2, r_v3;
    t_ctrl r_c1, r_c2, r_c3;

    // taps: left in low bits
    always_comb begin
        for (int kr = 0; kr < 3; kr++)
            for (int kc = 0; kc < 3; kc++)
                w_tap[kr][kc] = i_coef[kr][TAP_W*kc +: TAP_W];
    end

    // stage 1: tap * sample; result A takes window columns 0,1,2,
    // result B (right edge) takes columns 1,2,2
    always_comb begin
        int p;
        logic [8:0] smp;
        for (int e = 0; e < 2; e++)
            for (int ch = 0; ch < 3; ch++)
                for (int kr = 0; kr < 3; kr++)
                    for (int kc = 0; kc < 3; kc++) begin
                        p = (e == 0) ? kc : ((kc == 0) ? 1 : 2);
                        smp = i_ch_en[ch] ? {1'b0, i_win[p][kr][8*ch +: 8]} : 9'd0;
                        n_prod[e][ch][kr][kc] = w_tap[kr][kc] * $signed(smp);
                    end
    end

    // stage 2: sum across each kernel row
    always_comb begin
        for (int e = 0; e < 2; e++)
            for (int ch = 0; ch < 3; ch++)
                for (int kr = 0; kr < 3; kr++)
                    n_rsum[e][ch][kr] = 23'(r_prod[e][ch][kr][0])
                                      + 23'(r_prod[e][ch][kr][1])
                                      + 23'(r_prod[e][ch][kr][2]);
    end

    // stage 3: channel totals, then optional merge into channel 0
    always_comb begin
        for (int e = 0; e < 2; e++) begin
            for (int ch = 0; ch < 3; ch++)
                n_tot[e][ch] = SUM_W'(r_rsum[e][ch][0]) + SUM_W'(r_rsum[e][ch][1])
                             + SUM_W'(r_rsum[e][ch][2]);
            if (i_merge) begin
                n_sum[e][0] = n_tot[e][0] + n_tot[e][1] + n_tot[e][2];
                n_sum[e][1] = '0;
                n_sum[e][2] = '0;
            end else begin
                n_sum[e] = n_tot[e];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
            r_rsum <= n_rsum;
            o_sum  <= n_sum;
            r_c1   <= i_ctrl;
            r_c2   <= r_c1;
            r_c3   <= r_c2;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_ctrl  = r_c3;

endmodule
